[rtl/event_registration_match_table_macros.svh]
// assertion helpers used by the rtl
`ifndef EVENT_REGISTRATION_MATCH_TABLE_MACROS_SVH
`define EVENT_REGISTRATION_MATCH_TABLE_MACROS_SVH

// same-cycle implication, checked outside reset
`define ERMT_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define ERMT_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/ermt_pkg.sv]
package ermt_pkg;

    localparam int CMD_W      = 3;
    localparam int NODE_ID_W  = 4;
    localparam int EVENT_W    = 64;
    localparam int ROLE_W     = 2;
    localparam int PLEN_W     = 4;
    localparam int KIND_W     = 3;
    localparam int INDEX_W    = 5;
    localparam int NODE_W_MAX = 8;

    localparam int MAX_RESULTS = 64;
    localparam int CNT_W       = $clog2(MAX_RESULTS + 1);

    localparam int QDEPTH = 2;
    localparam int QPTR_W = 1;
    localparam int QCNT_W = 2;

    localparam logic [PLEN_W-1:0] FULL_PAYLOAD = 4'd8;

    // command codes
    localparam logic [CMD_W-1:0] CMD_CLEAR      = 3'd0;
    localparam logic [CMD_W-1:0] CMD_REGISTER   = 3'd1;
    localparam logic [CMD_W-1:0] CMD_IDENT_ALL  = 3'd2;
    localparam logic [CMD_W-1:0] CMD_CONS_IDENT = 3'd3;
    localparam logic [CMD_W-1:0] CMD_PROD_IDENT = 3'd4;
    localparam logic [CMD_W-1:0] CMD_REPORT     = 3'd5;

    // result kinds
    localparam logic [KIND_W-1:0] KIND_REGISTERED = 3'd0;
    localparam logic [KIND_W-1:0] KIND_FULL       = 3'd1;
    localparam logic [KIND_W-1:0] KIND_PROD_ID    = 3'd2;
    localparam logic [KIND_W-1:0] KIND_CONS_ID    = 3'd3;
    localparam logic [KIND_W-1:0] KIND_REPORT     = 3'd4;

    // classified command handed from front to back
    typedef struct packed {
        logic [CMD_W-1:0]      cmd;
        logic [NODE_W_MAX-1:0] node;
        logic [EVENT_W-1:0]    evt_id;
        logic [ROLE_W-1:0]     roles;
        logic                  handler;
    } ermt_cmd_t;

    typedef struct packed {
        logic [KIND_W-1:0]    kind;
        logic [NODE_ID_W-1:0] node;
        logic [EVENT_W-1:0]   evt_id;
        logic [INDEX_W-1:0]   idx;
        logic                 last;
    } ermt_res_t;

endpackage

[rtl/ermt_in_if.sv]
interface ermt_in_if;
    import ermt_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [CMD_W-1:0]     cmd;
    logic [NODE_ID_W-1:0] node_id;
    logic [EVENT_W-1:0]   evt_id;
    logic [ROLE_W-1:0]    role_flags;
    logic                 has_handler;
    logic [PLEN_W-1:0]    payload_len;

    modport source (
        output valid, cmd, node_id, evt_id, role_flags, has_handler, payload_len,
        input  ready
    );

    modport sink (
        input  valid, cmd, node_id, evt_id, role_flags, has_handler, payload_len,
        output ready
    );
endinterface

[rtl/ermt_out_if.sv]
interface ermt_out_if;
    import ermt_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [KIND_W-1:0]    kind;
    logic [NODE_ID_W-1:0] out_node;
    logic [EVENT_W-1:0]   out_event;
    logic [INDEX_W-1:0]   entry_index;
    logic                 last;

    modport source (
        output valid, kind, out_node, out_event, entry_index, last,
        input  ready
    );

    modport sink (
        input  valid, kind, out_node, out_event, entry_index, last,
        output ready
    );
endinterface

[rtl/ermt_front.sv]
module ermt_front #(
    parameter int NODE_BITS = 4
) (
    input  logic              clk,
    input  logic              rst_n,
    ermt_in_if.sink           in_ch,
    output logic              cmd_valid,
    input  logic              cmd_ready,
    output ermt_pkg::ermt_cmd_t cmd
);
    import ermt_pkg::*;

    localparam logic [NODE_W_MAX-1:0] NODE_MASK = ~({NODE_W_MAX{1'b1}} << NODE_BITS);

    ermt_cmd_t          q_reg [QDEPTH];
    logic [QPTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0]  cnt_reg, cnt_next;
    logic               keep;
    logic               push;
    logic               pop;
    ermt_cmd_t          classified;

    // drop unknown codes and identify or report frames with a short payload
    always_comb
    begin
        keep = (in_ch.cmd inside {CMD_CLEAR, CMD_REGISTER, CMD_IDENT_ALL})
            || ((in_ch.cmd inside {CMD_CONS_IDENT, CMD_PROD_IDENT, CMD_REPORT})
                && (in_ch.payload_len >= FULL_PAYLOAD));
        classified.cmd      = in_ch.cmd;
        classified.node     = NODE_W_MAX'(in_ch.node_id) & NODE_MASK;
        classified.evt_id   = in_ch.evt_id;
        classified.roles    = in_ch.role_flags;
        classified.handler  = in_ch.has_handler;
    end

    assign in_ch.ready = (cnt_reg != QCNT_W'(QDEPTH));
    assign push        = in_ch.valid && in_ch.ready && keep;
    assign cmd_valid   = (cnt_reg != '0);
    assign pop         = cmd_valid && cmd_ready;
    assign cmd         = q_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        cnt_next    = cnt_reg + QCNT_W'(push) - QCNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wr_ptr_reg] <= classified;
        end
    end
endmodule

[rtl/ermt_back.sv]
`include "event_registration_match_table_macros.svh"

module ermt_back #(
    parameter int ENTRIES   = 32,
    parameter int NODE_BITS = 4
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cmd_valid,
    output logic                cmd_ready,
    input  ermt_pkg::ermt_cmd_t cmd,
    ermt_out_if.source          out_ch
);
    import ermt_pkg::*;

    localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int MEM_W = EVENT_W + 3 + NODE_BITS;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_REG   = 4'b0010,
        S_SCAN  = 4'b0100,
        S_DRAIN = 4'b1000
    } state_t;

    // event, flags and node of each slot; only used behind a set valid bit
    logic [MEM_W-1:0]   mem [ENTRIES];
    logic [MEM_W-1:0]   rd_data_reg;
    logic               mem_we;
    logic               rd_en;
    logic [MEM_W-1:0]   wdata;

    state_t             state_reg, state_next;
    logic [ENTRIES-1:0] valid_reg, valid_next;
    logic [IDX_W-1:0]   ptr_reg, ptr_next;
    logic               iss_done_reg, iss_done_next;
    logic               ev_vld_reg, ev_vld_next;
    logic               ev_ent_reg, ev_ent_next;
    logic [IDX_W-1:0]   ev_idx_reg, ev_idx_next;
    logic               phase_reg, phase_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic               pend_vld_reg, pend_vld_next;
    ermt_res_t          pend_reg, pend_next;
    logic               out_vld_reg, out_vld_next;
    ermt_res_t          out_reg, out_next;
    ermt_cmd_t          cur_reg, cur_next;

    logic [EVENT_W-1:0]   rd_event;
    logic                 rd_prod;
    logic                 rd_cons;
    logic                 rd_hdl;
    logic [NODE_BITS-1:0] rd_node;
    logic                 node_hit;
    logic                 ev_eq;
    logic                 hit;
    logic                 hold;
    logic                 first_only;
    logic [KIND_W-1:0]    hit_kind;
    logic                 take;
    logic                 stall;
    logic                 out_free;
    ermt_res_t            scan_res;

    assign rd_event = rd_data_reg[EVENT_W-1:0];
    assign rd_prod  = rd_data_reg[EVENT_W];
    assign rd_cons  = rd_data_reg[EVENT_W+1];
    assign rd_hdl   = rd_data_reg[EVENT_W+2];
    assign rd_node  = rd_data_reg[MEM_W-1 -: NODE_BITS];
    assign wdata    = {cur_reg.node[NODE_BITS-1:0], cur_reg.handler,
                       cur_reg.roles[1], cur_reg.roles[0], cur_reg.evt_id};
    assign out_free = !out_vld_reg || out_ch.ready;

    // match of the slot under evaluation
    always_comb
    begin
        node_hit   = ev_vld_reg && ev_ent_reg && (rd_node == cur_reg.node[NODE_BITS-1:0]);
        ev_eq      = (rd_event == cur_reg.evt_id);
        hit        = 1'b0;
        hold       = 1'b0;
        first_only = 1'b0;
        hit_kind   = KIND_PROD_ID;
        case (cur_reg.cmd)
            CMD_IDENT_ALL:
            begin
                if (node_hit)
                begin
                    if (phase_reg)
                    begin
                        hit      = 1'b1;
                        hit_kind = KIND_CONS_ID;
                    end
                    else if (rd_prod)
                    begin
                        hit  = 1'b1;
                        hold = rd_cons;
                    end
                    else if (rd_cons)
                    begin
                        hit      = 1'b1;
                        hit_kind = KIND_CONS_ID;
                    end
                end
            end
            CMD_CONS_IDENT:
            begin
                first_only = 1'b1;
                hit        = node_hit && rd_cons && ev_eq;
                hit_kind   = KIND_CONS_ID;
            end
            CMD_PROD_IDENT:
            begin
                first_only = 1'b1;
                hit        = node_hit && rd_prod && ev_eq;
            end
            CMD_REPORT:
            begin
                hit      = node_hit && rd_cons && rd_hdl && ev_eq;
                hit_kind = KIND_REPORT;
            end
            default:
            begin
                hit = 1'b0;
            end
        endcase
        take  = hit && (cnt_reg < CNT_W'(MAX_RESULTS));
        stall = take && pend_vld_reg && !out_free;

        scan_res.kind     = hit_kind;
        scan_res.node     = NODE_ID_W'(cur_reg.node);
        scan_res.evt_id   = rd_event;
        scan_res.idx      = INDEX_W'(ev_idx_reg);
        scan_res.last     = 1'b0;
    end

    always_comb
    begin
        state_next    = state_reg;
        valid_next    = valid_reg;
        ptr_next      = ptr_reg;
        iss_done_next = iss_done_reg;
        ev_vld_next   = ev_vld_reg;
        ev_ent_next   = ev_ent_reg;
        ev_idx_next   = ev_idx_reg;
        phase_next    = phase_reg;
        cnt_next      = cnt_reg;
        pend_vld_next = pend_vld_reg;
        pend_next     = pend_reg;
        out_vld_next  = out_vld_reg && !out_ch.ready;
        out_next      = out_reg;
        cur_next      = cur_reg;
        mem_we        = 1'b0;
        rd_en         = 1'b0;
        cmd_ready     = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                cmd_ready = 1'b1;
                if (cmd_valid)
                begin
                    cur_next = cmd;
                    ptr_next = '0;
                    case (cmd.cmd)
                        CMD_CLEAR:
                        begin
                            valid_next = '0;
                        end
                        CMD_REGISTER:
                        begin
                            state_next = S_REG;
                        end
                        default:
                        begin
                            iss_done_next = 1'b0;
                            ev_vld_next   = 1'b0;
                            phase_next    = 1'b0;
                            cnt_next      = '0;
                            state_next    = S_SCAN;
                        end
                    endcase
                end
            end
            S_REG:
            begin
                pend_next.node     = NODE_ID_W'(cur_reg.node);
                pend_next.evt_id   = cur_reg.evt_id;
                pend_next.last     = 1'b0;
                if (!valid_reg[ptr_reg])
                begin
                    mem_we              = 1'b1;
                    valid_next[ptr_reg] = 1'b1;
                    pend_vld_next       = 1'b1;
                    pend_next.kind      = KIND_REGISTERED;
                    pend_next.idx       = INDEX_W'(ptr_reg);
                    state_next          = S_DRAIN;
                end
                else if (ptr_reg == LAST_IDX)
                begin
                    pend_vld_next  = 1'b1;
                    pend_next.kind = KIND_FULL;
                    pend_next.idx  = '0;
                    state_next     = S_DRAIN;
                end
                else
                begin
                    ptr_next = ptr_reg + 1'b1;
                end
            end
            S_SCAN:
            begin
                if (iss_done_reg && !ev_vld_reg)
                begin
                    state_next = S_DRAIN;
                end
                else if (!stall)
                begin
                    if (take)
                    begin
                        pend_vld_next = 1'b1;
                        pend_next     = scan_res;
                        cnt_next      = cnt_reg + 1'b1;
                        // older result is now known not to be the final one
                        if (pend_vld_reg)
                        begin
                            out_vld_next = 1'b1;
                            out_next     = pend_reg;
                        end
                    end
                    phase_next = hold;
                    if (take && first_only)
                    begin
                        ev_vld_next = 1'b0;
                        state_next  = S_DRAIN;
                    end
                    else if (!hold)
                    begin
                        if (!iss_done_reg)
                        begin
                            rd_en         = 1'b1;
                            ev_vld_next   = 1'b1;
                            ev_ent_next   = valid_reg[ptr_reg];
                            ev_idx_next   = ptr_reg;
                            ptr_next      = ptr_reg + 1'b1;
                            iss_done_next = (ptr_reg == LAST_IDX);
                        end
                        else
                        begin
                            ev_vld_next = 1'b0;
                        end
                    end
                end
            end
            S_DRAIN:
            begin
                if (!pend_vld_reg)
                begin
                    state_next = S_IDLE;
                end
                else if (out_free)
                begin
                    out_vld_next  = 1'b1;
                    out_next      = pend_reg;
                    out_next.last = 1'b1;
                    pend_vld_next = 1'b0;
                    state_next    = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            valid_reg    <= '0;
            ptr_reg      <= '0;
            iss_done_reg <= 1'b0;
            ev_vld_reg   <= 1'b0;
            phase_reg    <= 1'b0;
            cnt_reg      <= '0;
            pend_vld_reg <= 1'b0;
            out_vld_reg  <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            valid_reg    <= valid_next;
            ptr_reg      <= ptr_next;
            iss_done_reg <= iss_done_next;
            ev_vld_reg   <= ev_vld_next;
            phase_reg    <= phase_next;
            cnt_reg      <= cnt_next;
            pend_vld_reg <= pend_vld_next;
            out_vld_reg  <= out_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ev_ent_reg <= ev_ent_next;
        ev_idx_reg <= ev_idx_next;
        pend_reg   <= pend_next;
        out_reg    <= out_next;
        cur_reg    <= cur_next;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[ptr_reg] <= wdata;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[ptr_reg];
        end
    end

    assign out_ch.valid       = out_vld_reg;
    assign out_ch.kind        = out_reg.kind;
    assign out_ch.out_node    = out_reg.node;
    assign out_ch.out_event   = out_reg.evt_id;
    assign out_ch.entry_index = out_reg.idx;
    assign out_ch.last        = out_reg.last;

    `ERMT_ASSERT_IMP(a_idle_no_pending, clk, rst_n, state_reg == S_IDLE, !pend_vld_reg,
        "pending result left behind in idle")
    `ERMT_ASSERT_IMP(a_cnt_capped, clk, rst_n, 1'b1, cnt_reg <= CNT_W'(MAX_RESULTS),
        "result count beyond cap")
    `ERMT_ASSERT_IMP(a_eval_in_scan, clk, rst_n, ev_vld_reg, state_reg == S_SCAN,
        "slot under evaluation outside scan")
    `ERMT_ASSERT_IMP(a_phase_with_slot, clk, rst_n, phase_reg, ev_vld_reg,
        "second reply pending without a slot")
    `ERMT_ASSERT_NXT(a_drain_to_idle, clk, rst_n,
        state_reg == S_DRAIN && (!pend_vld_reg || out_free), state_reg == S_IDLE,
        "drain did not finish")
endmodule

[rtl/event_registration_match_table.sv]
// event registration and match table
//
// in_ch takes one command transaction per handshake (valid and ready high):
// clear, register, identify all, consumer identify, producer identify or
// event report. identify and report frames with a payload under 8 bytes,
// and unknown codes, are taken and dropped. out_ch gives the results of
// each command in order, last set on the final one of that command.
// a front end classifies and queues up to two commands, so in_ch keeps
// taking transactions while the back end works on an earlier one.
// clear empties the table from the back end's idle state; register walks
// over the valid bits for the first free slot; every search command walks
// the table, reading one slot per cycle from the single-port table memory
// while out_ch does not stall it, and an identify-all slot that is both
// producer and consumer holds the walk for its second result.
// a result waits in a pending register until the next match or the end of
// the walk, then goes through the output register to out_ch.
// reset clears the valid bits in flip-flops at once, so the table is empty
// with no clearing pass; queued commands and pending results are dropped.
// when out_ch stalls, one result waits in the output register and one more
// in a pending register; after that the scan halts in place until taken.
module event_registration_match_table #(
    parameter int ENTRIES   = 32,
    parameter int NODE_BITS = 4
) (
    input  logic      clk,
    input  logic      rst_n,
    ermt_in_if.sink   in_ch,
    ermt_out_if.source out_ch
);
    import ermt_pkg::*;

    // classified command between the two halves
    ermt_cmd_t cmd;
    logic      cmd_valid;
    logic      cmd_ready;

    // front: classify and queue
    ermt_front #(
        .NODE_BITS (NODE_BITS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ch     (in_ch),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd       (cmd)
    );

    // back: table walk and result output
    ermt_back #(
        .ENTRIES   (ENTRIES),
        .NODE_BITS (NODE_BITS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd       (cmd),
        .out_ch    (out_ch)
    );
endmodule

[test/tb_top.sv]
`timescale 1ns / 100ps

// exercises the event registration table: directed register / identify / report
// transactions first, then episodes of random traffic, each starting from a
// cleared table, under three idling patterns on the command and result channels
module tb_top;
    import ermt_pkg::*;

    localparam int TABLE_SLOTS = 32;

    // codes the block does not know, it must take and drop them
    localparam logic [CMD_W-1:0] CMD_UNUSED_6 = 3'd6;
    localparam logic [CMD_W-1:0] CMD_UNUSED_7 = 3'd7;

    localparam logic [EVENT_W-1:0] ALL_ONES  = '1;
    localparam logic [EVENT_W-1:0] MID_EVENT = 64'h0123_4567_89ab_cdef;

    // one command transaction as it goes onto the input channel
    typedef struct packed {
        logic [CMD_W-1:0]     cmd;
        logic [NODE_ID_W-1:0] node;
        logic [EVENT_W-1:0]   evt_id;
        logic [ROLE_W-1:0]    roles;
        logic                 handler;
        logic [PLEN_W-1:0]    plen;
    } cmd_txn_t;

    logic clk = 1'b0;
    logic rst_n;

    ermt_in_if  cmd_bus ();
    ermt_out_if result_bus ();

    event_registration_match_table #(
        .ENTRIES   (TABLE_SLOTS),
        .NODE_BITS (NODE_ID_W)
    ) dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (cmd_bus),
        .out_ch (result_bus)
    );

    // 4 ns period
    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // idle chance per cycle, in percent, for each side
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int mismatch_count = 0;

    // shadow copy of the registration table
    bit                   slot_valid   [TABLE_SLOTS];
    bit                   slot_prod    [TABLE_SLOTS];
    bit                   slot_cons    [TABLE_SLOTS];
    bit                   slot_handler [TABLE_SLOTS];
    bit [NODE_ID_W-1:0]   slot_node    [TABLE_SLOTS];
    bit [EVENT_W-1:0]     slot_event   [TABLE_SLOTS];

    // results still owed by the block, oldest first
    ermt_res_t expected_results[$];
    ermt_res_t oldest_result;

    // small set of events per episode so that lookups actually hit
    logic [EVENT_W-1:0] event_pool[4];

    function automatic cmd_txn_t make_cmd(
        input logic [CMD_W-1:0]     cmd,
        input logic [NODE_ID_W-1:0] node,
        input logic [EVENT_W-1:0]   ev,
        input logic [ROLE_W-1:0]    roles,
        input logic                 handler,
        input logic [PLEN_W-1:0]    plen
    );
        cmd_txn_t t;
        t.cmd      = cmd;
        t.node     = node;
        t.evt_id   = ev;
        t.roles    = roles;
        t.handler  = handler;
        t.plen     = plen;
        return t;
    endfunction

    function automatic ermt_res_t make_result(
        input logic [KIND_W-1:0]    kind,
        input logic [NODE_ID_W-1:0] node,
        input logic [EVENT_W-1:0]   ev,
        input int                   slot
    );
        ermt_res_t r;
        r.kind     = kind;
        r.node     = node;
        r.evt_id   = ev;
        r.idx      = INDEX_W'(slot);
        r.last     = 1'b0;
        return r;
    endfunction

    function automatic bit slot_owned(input int i, input logic [NODE_ID_W-1:0] node);
        return slot_valid[i] && (slot_node[i] == node);
    endfunction

    // table update and result list for one accepted command
    function automatic void predict_results(input cmd_txn_t t);
        ermt_res_t found[$];
        int        free_slot;
        bit        full_frame;
        bit        want_cons;
        full_frame = (t.plen >= FULL_PAYLOAD);
        want_cons  = (t.cmd == CMD_CONS_IDENT);
        case (t.cmd)
            CMD_CLEAR:
            begin
                foreach (slot_valid[i])
                    slot_valid[i] = 1'b0;
            end
            CMD_REGISTER:
            begin
                // lowest free slot wins, zero roles still take a slot
                free_slot = -1;
                for (int i = TABLE_SLOTS - 1; i >= 0; i--)
                    if (!slot_valid[i])
                        free_slot = i;
                if (free_slot < 0)
                    found.push_back(make_result(KIND_FULL, t.node, t.evt_id, 0));
                else
                begin
                    slot_valid[free_slot]   = 1'b1;
                    slot_prod[free_slot]    = t.roles[0];
                    slot_cons[free_slot]    = t.roles[1];
                    slot_handler[free_slot] = t.handler;
                    slot_node[free_slot]    = t.node;
                    slot_event[free_slot]   = t.evt_id;
                    found.push_back(make_result(KIND_REGISTERED, t.node, t.evt_id,
                                                free_slot));
                end
            end
            CMD_IDENT_ALL:
            begin
                // payload length plays no part here
                for (int i = 0; i < TABLE_SLOTS; i++)
                begin
                    if (slot_owned(i, t.node))
                    begin
                        if (slot_prod[i])
                            found.push_back(make_result(KIND_PROD_ID, t.node,
                                                        slot_event[i], i));
                        if (slot_cons[i])
                            found.push_back(make_result(KIND_CONS_ID, t.node,
                                                        slot_event[i], i));
                    end
                end
            end
            CMD_CONS_IDENT, CMD_PROD_IDENT:
            begin
                // first matching slot only
                for (int i = 0; i < TABLE_SLOTS; i++)
                begin
                    if (full_frame && found.size() == 0 && slot_owned(i, t.node)
                        && (want_cons ? slot_cons[i] : slot_prod[i])
                        && slot_event[i] == t.evt_id)
                        found.push_back(make_result(want_cons ? KIND_CONS_ID : KIND_PROD_ID,
                                                    t.node, t.evt_id, i));
                end
            end
            CMD_REPORT:
            begin
                for (int i = 0; i < TABLE_SLOTS; i++)
                begin
                    if (full_frame && slot_owned(i, t.node) && slot_cons[i]
                        && slot_handler[i] && slot_event[i] == t.evt_id)
                        found.push_back(make_result(KIND_REPORT, t.node, t.evt_id, i));
                end
            end
            default:
            begin
            end
        endcase
        if (found.size() != 0)
            found[found.size() - 1].last = 1'b1;
        foreach (found[i])
            expected_results.push_back(found[i]);
    endfunction

    // drive one command, hold it until the handshake, then predict
    // called and returns at a falling edge, valid stays high between
    // back-to-back transactions
    task automatic issue_command(input cmd_txn_t t);
        while ($urandom_range(99) < send_idle_pct)
        begin
            cmd_bus.valid <= 1'b0;
            @(negedge clk);
        end
        cmd_bus.valid       <= 1'b1;
        cmd_bus.cmd         <= t.cmd;
        cmd_bus.node_id     <= t.node;
        cmd_bus.evt_id      <= t.evt_id;
        cmd_bus.role_flags  <= t.roles;
        cmd_bus.has_handler <= t.handler;
        cmd_bus.payload_len <= t.plen;
        do
            @(posedge clk);
        while (!cmd_bus.ready);
        predict_results(t);
        @(negedge clk);
    endtask

    // hold off the sender until every owed result has come back
    task automatic wait_for_results();
        cmd_bus.valid <= 1'b0;
        do
            @(negedge clk);
        while (expected_results.size() != 0);
    endtask

    function automatic void refill_event_pool();
        foreach (event_pool[i])
        begin
            case ($urandom_range(7))
                0:       event_pool[i] = '0;
                1:       event_pool[i] = ALL_ONES;
                default: event_pool[i] = {$urandom, $urandom};
            endcase
        end
    endfunction

    function automatic logic [EVENT_W-1:0] pick_event();
        if ($urandom_range(99) < 80)
            return event_pool[$urandom_range(3)];
        return {$urandom, $urandom};
    endfunction

    // receiver side: random back-pressure
    always @(negedge clk)
        result_bus.ready <= ($urandom_range(99) >= recv_idle_pct);

    function automatic void check_field(input string name, input logic [63:0] want,
                                        input logic [63:0] got);
        if (want !== got)
        begin
            $error("%s: expected %0h, actual %0h", name, want, got);
            mismatch_count++;
        end
    endfunction

    // every result transaction is matched against the oldest expectation
    always @(posedge clk)
    begin
        if (rst_n && result_bus.valid && result_bus.ready)
        begin
            if (expected_results.size() == 0)
            begin
                $error("result with none expected: kind %0d node %0d event %0h slot %0d",
                       result_bus.kind, result_bus.out_node, result_bus.out_event,
                       result_bus.entry_index);
                mismatch_count++;
            end
            else
            begin
                oldest_result = expected_results.pop_front();
                check_field("kind", 64'(oldest_result.kind), 64'(result_bus.kind));
                check_field("out_node", 64'(oldest_result.node), 64'(result_bus.out_node));
                check_field("out_event", oldest_result.evt_id, result_bus.out_event);
                check_field("entry_index", 64'(oldest_result.idx),
                            64'(result_bus.entry_index));
                check_field("last", 64'(oldest_result.last), 64'(result_bus.last));
            end
        end
    end

    // registration into the lowest free slot, zero roles, identify-all per node
    task automatic test_register_basics();
        issue_command(make_cmd(CMD_CLEAR, 4'd0, '0, 2'd0, 1'b0, 4'd0));
        issue_command(make_cmd(CMD_REGISTER, 4'd0, '0, 2'd0, 1'b0, 4'd0));
        issue_command(make_cmd(CMD_REGISTER, 4'd15, ALL_ONES, 2'd3, 1'b1, 4'd15));
        issue_command(make_cmd(CMD_REGISTER, 4'd15, MID_EVENT, 2'd1, 1'b0, 4'd8));
        issue_command(make_cmd(CMD_REGISTER, 4'd15, ALL_ONES, 2'd2, 1'b1, 4'd3));
        issue_command(make_cmd(CMD_REGISTER, 4'd15, ALL_ONES, 2'd2, 1'b0, 4'd0));
        // short payload is fine for identify-all
        issue_command(make_cmd(CMD_IDENT_ALL, 4'd15, '0, 2'd0, 1'b0, 4'd0));
        issue_command(make_cmd(CMD_IDENT_ALL, 4'd0, ALL_ONES, 2'd3, 1'b1, 4'd8));
    endtask

    // single identify: first match only, flag, node and payload length gates
    task automatic test_single_identify();
        issue_command(make_cmd(CMD_CONS_IDENT, 4'd15, ALL_ONES, 2'd0, 1'b0, 4'd8));
        issue_command(make_cmd(CMD_PROD_IDENT, 4'd15, MID_EVENT, 2'd3, 1'b1, 4'd15));
        issue_command(make_cmd(CMD_PROD_IDENT, 4'd15, ALL_ONES, 2'd0, 1'b0, 4'd8));
        issue_command(make_cmd(CMD_CONS_IDENT, 4'd15, MID_EVENT, 2'd0, 1'b0, 4'd8));
        issue_command(make_cmd(CMD_CONS_IDENT, 4'd15, ALL_ONES, 2'd0, 1'b0, 4'd7));
        issue_command(make_cmd(CMD_PROD_IDENT, 4'd14, ALL_ONES, 2'd0, 1'b0, 4'd8));
    endtask

    // report delivers to each consumer with a handler, short frames dropped
    task automatic test_event_report();
        issue_command(make_cmd(CMD_REPORT, 4'd15, ALL_ONES, 2'd0, 1'b0, 4'd8));
        issue_command(make_cmd(CMD_REPORT, 4'd15, ALL_ONES, 2'd3, 1'b1, 4'd0));
        issue_command(make_cmd(CMD_REPORT, 4'd0, '0, 2'd0, 1'b0, 4'd15));
    endtask

    // unknown codes are ignored, clear empties the table
    task automatic test_unknown_commands();
        issue_command(make_cmd(CMD_UNUSED_6, 4'd15, ALL_ONES, 2'd3, 1'b1, 4'd8));
        issue_command(make_cmd(CMD_UNUSED_7, 4'd15, ALL_ONES, 2'd3, 1'b1, 4'd15));
        issue_command(make_cmd(CMD_CLEAR, 4'd15, ALL_ONES, 2'd3, 1'b1, 4'd15));
        issue_command(make_cmd(CMD_IDENT_ALL, 4'd15, '0, 2'd0, 1'b0, 4'd8));
        issue_command(make_cmd(CMD_REGISTER, 4'd7, MID_EVENT, 2'd3, 1'b1, 4'd8));
    endtask

    // one node fills every slot as producer and consumer: table full,
    // then identify-all gives the largest burst of results
    task automatic test_full_table();
        logic [NODE_ID_W-1:0] node;
        refill_event_pool();
        node = NODE_ID_W'($urandom_range(15));
        issue_command(make_cmd(CMD_CLEAR, node, '0, 2'd0, 1'b0, 4'd0));
        for (int i = 0; i < TABLE_SLOTS + 2; i++)
            issue_command(make_cmd(CMD_REGISTER, node, event_pool[$urandom_range(1)], 2'd3,
                                   1'($urandom_range(1)), PLEN_W'($urandom_range(15))));
        issue_command(make_cmd(CMD_IDENT_ALL, node, '0, 2'd0, 1'b0, 4'd8));
        issue_command(make_cmd(CMD_REPORT, node, event_pool[0], 2'd0, 1'b0, 4'd8));
        issue_command(make_cmd(CMD_REPORT, node, event_pool[1], 2'd0, 1'b0, 4'd15));
        issue_command(make_cmd(CMD_CONS_IDENT, node, event_pool[1], 2'd0, 1'b0, 4'd9));
        issue_command(make_cmd(CMD_PROD_IDENT, node, event_pool[0], 2'd0, 1'b0, 4'd8));
    endtask

    // episodes: clear, then registrations mixed with lookups on a narrow
    // node range and a small event pool; dropped frames are extra noise
    task automatic run_random_traffic(input int target);
        int                   done_items;
        int                   episode_len;
        int                   reg_pct;
        logic [NODE_ID_W-1:0] node_base;
        logic [NODE_ID_W-1:0] node_span;
        logic [NODE_ID_W-1:0] node;
        cmd_txn_t             t;
        bit                   noise;
        done_items = 0;
        while (done_items < target)
        begin
            refill_event_pool();
            node_base = NODE_ID_W'($urandom_range(15));
            case ($urandom_range(3))
                0:       node_span = 4'd0;
                1:       node_span = 4'd1;
                2:       node_span = 4'd3;
                default: node_span = 4'd15;
            endcase
            reg_pct     = $urandom_range(1) ? 45 : 80;
            episode_len = $urandom_range(10, 50);
            issue_command(make_cmd(CMD_CLEAR, NODE_ID_W'($urandom_range(15)),
                                   {$urandom, $urandom}, ROLE_W'($urandom_range(3)),
                                   1'($urandom_range(1)), PLEN_W'($urandom_range(15))));
            done_items++;
            for (int k = 0; k < episode_len && done_items < target; k++)
            begin
                node  = NODE_ID_W'(node_base + $urandom_range(node_span));
                noise = 1'b0;
                t = make_cmd(CMD_REGISTER, node, pick_event(), ROLE_W'($urandom_range(3)),
                             1'($urandom_range(1)), PLEN_W'($urandom_range(15)));
                if ($urandom_range(99) >= reg_pct)
                begin
                    case ($urandom_range(9))
                        0, 1: t.cmd = CMD_IDENT_ALL;
                        2, 3: t.cmd = CMD_CONS_IDENT;
                        4, 5: t.cmd = CMD_PROD_IDENT;
                        6, 7, 8: t.cmd = CMD_REPORT;
                        default: noise = 1'b1;
                    endcase
                    if (t.cmd != CMD_IDENT_ALL)
                        t.plen = PLEN_W'($urandom_range(8, 15));
                    if (noise)
                    begin
                        // unknown code, or a lookup frame that is too short
                        if ($urandom_range(1))
                            t.cmd = $urandom_range(1) ? CMD_UNUSED_6 : CMD_UNUSED_7;
                        else
                        begin
                            t.cmd  = CMD_W'($urandom_range(3, 5));
                            t.plen = PLEN_W'($urandom_range(7));
                        end
                    end
                end
                issue_command(t);
                if (!noise)
                    done_items++;
            end
        end
    endtask

    initial
    begin
        rst_n                = 1'b0;
        cmd_bus.valid        = 1'b0;
        cmd_bus.cmd          = CMD_CLEAR;
        cmd_bus.node_id      = '0;
        cmd_bus.evt_id       = '0;
        cmd_bus.role_flags   = '0;
        cmd_bus.has_handler  = 1'b0;
        cmd_bus.payload_len  = '0;
        repeat (8) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // phase one: sender rarely idles, receiver mostly stalls
        send_idle_pct = 9;
        recv_idle_pct = 72;
        test_register_basics();
        test_single_identify();
        test_event_report();
        test_unknown_commands();
        wait_for_results();
        test_full_table();
        run_random_traffic(60);
        wait_for_results();

        // phase two: the other way round
        send_idle_pct = 72;
        recv_idle_pct = 9;
        run_random_traffic(70);
        wait_for_results();

        // phase three: full throughput on both sides
        send_idle_pct = 0;
        recv_idle_pct = 0;
        run_random_traffic(70);
        wait_for_results();

        // let any queued no-result commands finish, catches stray results
        repeat (4 * TABLE_SLOTS) @(posedge clk);
        if (mismatch_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    // hang guard, far beyond the slowest correct run
    initial
    begin
        #4_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule
